[hdl/bmpd_pkg.sv]
`timescale 1ns / 1ps
package bmpd_pkg;

    // Result kinds.
    localparam logic [1:0] KIND_PIXEL  = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_EMPTY  = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    // Error codes.
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_SIGNATURE = 3'd1;
    localparam logic [2:0] ERR_HEADER    = 3'd2;
    localparam logic [2:0] ERR_FORMAT    = 3'd3;
    localparam logic [2:0] ERR_TRUNCATED = 3'd4;
    localparam logic [2:0] ERR_SIZE      = 3'd5;

    // One result item, as it travels through the queue.
    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [11:0] column;
        logic [11:0] row;
        logic [12:0] width_out;
        logic [12:0] height_out;
        logic        top_down_out;
        logic        image_end;
        logic [2:0]  error_code;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

[hdl/bmpd_parser.sv]
`timescale 1ns / 1ps
// Parses the byte stream: header fields, skip, pixel assembly.
// Takes one byte per cycle whenever the queue behind it has room.
module bmpd_parser #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [7:0]         data_byte,
    input  logic               last_byte,
    output logic               res_valid,
    output bmpd_pkg::result_t  res
);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_SKIP   = 2'd1;
    localparam logic [1:0] PH_PIXELS = 2'd2;
    localparam logic [1:0] PH_DRAIN  = 2'd3;

    logic [1:0]  phase_reg;
    logic [31:0] pos_reg;
    logic [31:0] shift_reg;
    logic [31:0] start_reg;
    logic [12:0] width_reg, height_reg;
    logic        top_reg, four_reg, size_bad_reg;
    logic [1:0]  bip_reg;
    logic [12:0] col_reg, rows_reg;
    logic [14:0] rbc_reg;
    logic [7:0]  hb_reg, hg_reg, hr_reg;
    logic [14:0] stride_reg;

    logic [1:0]  phase_next;
    logic [31:0] pos_next, shift_next, start_next;
    logic [12:0] width_next, height_next, col_next, rows_next;
    logic        top_next, four_next, size_bad_next;
    logic [1:0]  bip_next;
    logic [14:0] rbc_next, stride_next;
    logic [7:0]  hb_next, hg_next, hr_next;
    logic        have;
    logic [2:0]  err;
    bmpd_pkg::result_t o;

    logic        fire;
    logic [31:0] fs;
    logic [31:0] mag;
    logic [1:0]  pix_phase;
    logic [14:0] rbc_inc;
    logic [12:0] rows_inc;

    assign fire = in_valid && in_ready;
    assign fs   = {data_byte, shift_reg[31:8]};
    assign mag  = fs[31] ? (32'd0 - fs) : fs;

    always_comb
    begin
        phase_next = phase_reg; pos_next = pos_reg; shift_next = shift_reg;
        start_next = start_reg; width_next = width_reg; height_next = height_reg;
        top_next = top_reg; four_next = four_reg; size_bad_next = size_bad_reg;
        bip_next = bip_reg; col_next = col_reg; rows_next = rows_reg;
        rbc_next = rbc_reg; hb_next = hb_reg; hg_next = hg_reg; hr_next = hr_reg;
        stride_next = stride_reg;
        have = 1'b0;
        err = bmpd_pkg::ERR_NONE;
        o = '0;
        rbc_inc = rbc_reg + 15'd1;
        rows_inc = rows_reg + 13'd1;
        pix_phase = phase_reg;

        // Header fields are checked on the byte that completes them.
        if (phase_reg == PH_HEADER)
        begin
            shift_next = fs;
            case (pos_reg)
                32'd1:  if (fs[31:16] != 16'h4D42) err = bmpd_pkg::ERR_SIGNATURE;
                32'd13: start_next = fs;
                32'd17: if (fs < 32'd40) err = bmpd_pkg::ERR_HEADER;
                32'd21:
                begin
                    if (fs[31] || fs > 32'(MAX_WIDTH)) size_bad_next = 1'b1;
                    else width_next = fs[12:0];
                end
                32'd25:
                begin
                    top_next = fs[31];
                    if (mag > 32'(MAX_HEIGHT)) size_bad_next = 1'b1;
                    else height_next = mag[12:0];
                end
                32'd27: if (fs[31:16] != 16'd1) err = bmpd_pkg::ERR_FORMAT;
                32'd29:
                begin
                    if (fs[31:16] == 16'd24) four_next = 1'b0;
                    else if (fs[31:16] == 16'd32) four_next = 1'b1;
                    else err = bmpd_pkg::ERR_FORMAT;
                end
                32'd33:
                begin
                    // Row stride, padded to four bytes.
                    stride_next = four_reg ? {width_reg[12:0], 2'b00}
                        : 15'(((17'(width_reg) * 17'd3) + 17'd3) & ~17'd3);
                    if (fs != 32'd0) err = bmpd_pkg::ERR_FORMAT;
                    else if (size_bad_reg || start_reg < 32'd34) err = bmpd_pkg::ERR_SIZE;
                    else if (width_reg == 13'd0 || height_reg == 13'd0)
                    begin
                        o.result_kind = bmpd_pkg::KIND_EMPTY;
                        o.image_end = 1'b1;
                        have = 1'b1;
                        phase_next = PH_DRAIN;
                    end
                    else
                    begin
                        o.result_kind = bmpd_pkg::KIND_HEADER;
                        have = 1'b1;
                        phase_next = PH_SKIP;
                    end
                    o.width_out = width_reg;
                    o.height_out = height_reg;
                    o.top_down_out = top_reg;
                end
                default: ;
            endcase
            pos_next = pos_reg + 32'd1;
        end
        else if (phase_reg == PH_SKIP)
        begin
            if (pos_reg < start_reg) pos_next = pos_reg + 32'd1;
            else
            begin
                phase_next = PH_PIXELS;
                pix_phase = PH_PIXELS;
            end
        end

        // Pixel assembly; padding bytes only advance the row byte counter.
        if (pix_phase == PH_PIXELS)
        begin
            if (col_reg < width_reg)
            begin
                if (bip_reg == 2'd0) hb_next = data_byte;
                if (bip_reg == 2'd1) hg_next = data_byte;
                if (bip_reg == 2'd2) hr_next = data_byte;
                if ((bip_reg == 2'd2 && !four_reg) || bip_reg == 2'd3)
                begin
                    o.result_kind = bmpd_pkg::KIND_PIXEL;
                    o.red = four_reg ? hr_reg : data_byte;
                    o.green = hg_reg;
                    o.blue = hb_reg;
                    o.alpha = four_reg ? data_byte : 8'd255;
                    o.column = col_reg[11:0];
                    o.row = top_reg ? rows_reg[11:0]
                        : 12'(height_reg - 13'd1 - rows_reg);
                    have = 1'b1;
                    bip_next = 2'd0;
                    col_next = col_reg + 13'd1;
                end
                else bip_next = bip_reg + 2'd1;
            end
            rbc_next = rbc_inc;
            if (rbc_inc >= stride_reg)
            begin
                rbc_next = '0;
                col_next = '0;
                bip_next = '0;
                rows_next = rows_inc;
                if (rows_inc >= height_reg)
                begin
                    phase_next = PH_DRAIN;
                    if (!have)
                    begin
                        o.result_kind = bmpd_pkg::KIND_EMPTY;
                        o.width_out = width_reg;
                        o.height_out = height_reg;
                        o.top_down_out = top_reg;
                        have = 1'b1;
                    end
                    o.image_end = 1'b1;
                end
            end
        end

        if (err == bmpd_pkg::ERR_NONE && last_byte && phase_next != PH_DRAIN)
            err = bmpd_pkg::ERR_TRUNCATED;

        if (err != bmpd_pkg::ERR_NONE)
        begin
            o = '0;
            o.result_kind = bmpd_pkg::KIND_ERROR;
            o.error_code = err;
            have = 1'b1;
            phase_next = PH_DRAIN;
        end

        // End of file returns everything but the row stride to the start state.
        if (last_byte)
        begin
            phase_next = PH_HEADER; pos_next = '0; shift_next = '0; start_next = '0;
            width_next = '0; height_next = '0; top_next = 1'b0; four_next = 1'b0;
            size_bad_next = 1'b0; bip_next = '0; col_next = '0; rows_next = '0;
            rbc_next = '0; hb_next = '0; hg_next = '0; hr_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER; pos_reg <= '0; shift_reg <= '0; start_reg <= '0;
            width_reg <= '0; height_reg <= '0; top_reg <= 1'b0; four_reg <= 1'b0;
            size_bad_reg <= 1'b0; bip_reg <= '0; col_reg <= '0; rows_reg <= '0;
            rbc_reg <= '0; hb_reg <= '0; hg_reg <= '0; hr_reg <= '0;
            stride_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next; pos_reg <= pos_next; shift_reg <= shift_next;
            start_reg <= start_next; width_reg <= width_next; height_reg <= height_next;
            top_reg <= top_next; four_reg <= four_next; size_bad_reg <= size_bad_next;
            bip_reg <= bip_next; col_reg <= col_next; rows_reg <= rows_next;
            rbc_reg <= rbc_next; hb_reg <= hb_next; hg_reg <= hg_next;
            hr_reg <= hr_next; stride_reg <= stride_next;
        end
    end

    assign res_valid = fire && have;
    assign res = o;

endmodule

[hdl/bmpd_queue.sv]
`timescale 1ns / 1ps
// Four-entry result queue between parser and output port.
module bmpd_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  bmpd_pkg::result_t  push_data,
    output logic               space,
    output logic               pop_valid,
    input  logic               pop_ready,
    output bmpd_pkg::result_t  pop_data
);

    bmpd_pkg::result_t mem_reg [4];
    logic [1:0] wr_reg, rd_reg;
    logic [2:0] cnt_reg;
    logic       pop;

    assign pop_valid = cnt_reg != 3'd0;
    assign pop = pop_valid && pop_ready;
    // Room is judged on the count alone, so it never waits on the output side.
    assign space = cnt_reg < 3'd3;
    assign pop_data = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0; rd_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            if (push) wr_reg <= wr_reg + 2'd1;
            if (pop) rd_reg <= rd_reg + 2'd1;
            cnt_reg <= cnt_reg + 3'(push) - 3'(pop);
        end
    end

endmodule

[hdl/bmp_to_rgba_decoder_unit.sv]
`timescale 1ns / 1ps
// BMP decoder for uncompressed 24 and 32 bpp files: one file byte is taken per
// clock while the result queue has room; a byte yields at most one result
// (pixel, header info, empty-image or error). Results pass through a small
// queue, so input stops only when that queue holds three results the output
// side has not yet taken. No clearing pass is needed after reset.
module bmp_to_rgba_decoder_unit #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // red, green, blue, alpha, column, row,
                                   // width_out, height_out, top_down_out,
                                   // error_code, zero fill
    output logic        m_tlast,   // image_end
    output logic [1:0]  m_tuser    // result_kind
);

    logic              res_valid;
    bmpd_pkg::result_t res, q;

    bmpd_parser #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_parser (
        .clk(clk), .rst_n(rst_n), .in_valid(s_tvalid), .in_ready(s_tready),
        .data_byte(s_tdata), .last_byte(s_tlast),
        .res_valid(res_valid), .res(res)
    );

    bmpd_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(res_valid), .push_data(res),
        .space(s_tready), .pop_valid(m_tvalid), .pop_ready(m_tready),
        .pop_data(q)
    );

    // Pack output fields, first field lowest.
    assign m_tdata = {2'd0, q.error_code, q.top_down_out, q.height_out, q.width_out,
                      q.row, q.column, q.alpha, q.blue, q.green, q.red};
    assign m_tlast = q.image_end;
    assign m_tuser = q.result_kind;

endmodule

[tb/bmp_to_rgba_decoder_unit_tb.sv]
`timescale 1ns / 1ps
module bmp_to_rgba_decoder_unit_tb;

    localparam int LIMIT_CYCLES = 600000;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAXW         = 4096;
    localparam int MAXH         = 4096;

    // Decoder phases tracked by the predictor.
    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_SKIP   = 2'd1;
    localparam logic [1:0] PH_PIXELS = 2'd2;
    localparam logic [1:0] PH_DRAIN  = 2'd3;

    // Header flaws that the file builder can inject.
    localparam int FLAW_NONE  = 0;
    localparam int FLAW_SIG   = 1;
    localparam int FLAW_INFO  = 2;
    localparam int FLAW_PLANE = 3;
    localparam int FLAW_COMP  = 4;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;

    bmp_to_rgba_decoder_unit uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .m_tuser(m_tuser)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    bmpd_pkg::result_t pending_results[$];
    logic [8:0]  file_bytes[$];
    int          errors = 0;
    int          cycles = 0;
    bit          quiet = 1'b0;
    bit          hold_req = 1'b0;

    // Decoder state mirrored by the predictor.
    logic [1:0]  phase;
    int unsigned pos, shift_reg, data_start, img_w, img_h, top_first, four_bpp;
    int unsigned pix_byte, col_cnt, rows_cnt, row_bytes, hold_b, hold_g, hold_r, size_bad;

    function automatic void clear_decoder();
        phase = PH_HEADER;
        pos = 0; shift_reg = 0; data_start = 0; img_w = 0; img_h = 0;
        top_first = 0; four_bpp = 0; pix_byte = 0; col_cnt = 0; rows_cnt = 0;
        row_bytes = 0; hold_b = 0; hold_g = 0; hold_r = 0; size_bad = 0;
    endfunction

    function automatic void set_geometry(ref bmpd_pkg::result_t r);
        r.width_out    = img_w[12:0];
        r.height_out   = img_h[12:0];
        r.top_down_out = top_first[0];
    endfunction

    // Works out the result, if any, that one accepted file byte causes.
    function automatic bit decode_byte(input logic [7:0] b, input logic last,
                                       output bmpd_pkg::result_t r);
        logic [2:0]  code;
        bit          have;
        int unsigned bpb, stride, mag, bpp;
        code = bmpd_pkg::ERR_NONE;
        have = 1'b0;
        r = '0;
        if (phase == PH_HEADER)
        begin
            shift_reg = (shift_reg >> 8) | (32'(b) << 24);
            case (pos)
                1: if ((shift_reg >> 16) != 32'h4D42) code = bmpd_pkg::ERR_SIGNATURE;
                13: data_start = shift_reg;
                17: if (shift_reg < 40) code = bmpd_pkg::ERR_HEADER;
                21:
                begin
                    if (shift_reg[31] || shift_reg > MAXW) size_bad = 1;
                    else img_w = shift_reg;
                end
                25:
                begin
                    mag = shift_reg[31] ? (0 - shift_reg) : shift_reg;
                    top_first = shift_reg[31];
                    if (mag > MAXH) size_bad = 1;
                    else img_h = mag;
                end
                27: if ((shift_reg >> 16) != 1) code = bmpd_pkg::ERR_FORMAT;
                29:
                begin
                    bpp = shift_reg >> 16;
                    if (bpp == 24) four_bpp = 0;
                    else if (bpp == 32) four_bpp = 1;
                    else code = bmpd_pkg::ERR_FORMAT;
                end
                33:
                begin
                    if (shift_reg != 0) code = bmpd_pkg::ERR_FORMAT;
                    else if (size_bad != 0 || data_start < 34) code = bmpd_pkg::ERR_SIZE;
                    else if (img_w == 0 || img_h == 0)
                    begin
                        r.result_kind = bmpd_pkg::KIND_EMPTY;
                        set_geometry(r);
                        r.image_end = 1'b1;
                        have = 1'b1;
                        phase = PH_DRAIN;
                    end
                    else
                    begin
                        r.result_kind = bmpd_pkg::KIND_HEADER;
                        set_geometry(r);
                        have = 1'b1;
                        phase = PH_SKIP;
                    end
                end
                default: ;
            endcase
            pos++;
        end
        else if (phase == PH_SKIP)
        begin
            if (pos < data_start) pos++;
            else phase = PH_PIXELS;
        end

        // Pixel assembly; the stride includes the padding to four bytes.
        if (phase == PH_PIXELS && !have)
        begin
            bpb = 3 + four_bpp;
            stride = (img_w * bpb + 3) & ~32'd3;
            if (col_cnt < img_w)
            begin
                if (pix_byte == 0) hold_b = b;
                else if (pix_byte == 1) hold_g = b;
                else if (pix_byte == 2) hold_r = b;
                if (pix_byte + 1 >= bpb)
                begin
                    r.result_kind = bmpd_pkg::KIND_PIXEL;
                    r.red   = hold_r[7:0];
                    r.green = hold_g[7:0];
                    r.blue  = hold_b[7:0];
                    r.alpha = four_bpp ? b : 8'hFF;
                    r.column = col_cnt[11:0];
                    r.row = top_first ? rows_cnt[11:0] : 12'(img_h - 1 - rows_cnt);
                    have = 1'b1;
                    pix_byte = 0;
                    col_cnt++;
                end
                else
                begin
                    pix_byte = (pix_byte + 1) & 3;
                end
            end
            row_bytes++;
            if (row_bytes >= stride)
            begin
                row_bytes = 0;
                col_cnt = 0;
                pix_byte = 0;
                rows_cnt++;
                if (rows_cnt >= img_h)
                begin
                    phase = PH_DRAIN;
                    if (!have)
                    begin
                        r.result_kind = bmpd_pkg::KIND_EMPTY;
                        set_geometry(r);
                        have = 1'b1;
                    end
                    r.image_end = 1'b1;
                end
            end
        end

        if (code == bmpd_pkg::ERR_NONE && last && phase != PH_DRAIN)
            code = bmpd_pkg::ERR_TRUNCATED;
        if (code != bmpd_pkg::ERR_NONE)
        begin
            r = '0;
            r.result_kind = bmpd_pkg::KIND_ERROR;
            r.error_code = code;
            have = 1'b1;
            phase = PH_DRAIN;
        end
        if (last) clear_decoder();
        return have;
    endfunction

    // Offers one byte, waits for the handshake and records what it should cause.
    task automatic send_byte(input logic [7:0] d, input logic l,
                             output bit have, output bmpd_pkg::result_t r);
        if (!quiet && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 7))
            begin
                @(negedge clk);
                s_tvalid = 1'b0;
            end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata  = d;
        s_tlast  = l;
        do @(posedge clk); while (!s_tready);
        have = decode_byte(d, l, r);
        if (have) pending_results.push_back(r);
    endtask

    task automatic put32(input int unsigned v);
        for (int i = 0; i < 4; i++) file_bytes.push_back({1'b0, 8'(v >> (8 * i))});
    endtask

    // Builds one file into the byte queue; cut_at below zero keeps it whole.
    task automatic build_file(input int w, input int h, input int bpp, input int off,
                              input int flaw, input int cut_at, input int tail);
        int unsigned stride, total, habs;
        logic [8:0]  lastb;
        file_bytes.delete();
        file_bytes.push_back({1'b0, (flaw == FLAW_SIG && $urandom_range(0, 1)) ?
                              8'($urandom) : 8'h42});
        file_bytes.push_back({1'b0, (flaw == FLAW_SIG) ? 8'h4C : 8'h4D});
        put32($urandom);
        put32($urandom);
        put32(off);
        put32((flaw == FLAW_INFO) ? $urandom_range(0, 39) : 40 + $urandom_range(0, 3) * 40);
        put32(w);
        put32(h);
        file_bytes.push_back({1'b0, (flaw == FLAW_PLANE) ? 8'($urandom_range(2, 255)) : 8'd1});
        file_bytes.push_back({1'b0, (flaw == FLAW_PLANE) ? 8'($urandom) : 8'd0});
        file_bytes.push_back({1'b0, 8'(bpp)});
        file_bytes.push_back({1'b0, 8'(bpp >> 8)});
        put32((flaw == FLAW_COMP) ? $urandom_range(1, 3) : 0);
        while (file_bytes.size() < off) file_bytes.push_back({1'b0, 8'($urandom)});
        habs = (h < 0) ? -h : h;
        stride = ((w > 0 ? w : 0) * ((bpp == 32) ? 4 : 3) + 3) & ~32'd3;
        if (w > 0 && w <= MAXW && habs <= MAXH) total = file_bytes.size() + stride * habs;
        else total = file_bytes.size();
        while (file_bytes.size() < total + tail) file_bytes.push_back({1'b0, 8'($urandom)});
        if (cut_at >= 0 && cut_at < file_bytes.size())
            while (file_bytes.size() > cut_at + 1) void'(file_bytes.pop_back());
        lastb = file_bytes.pop_back();
        file_bytes.push_back({1'b1, lastb[7:0]});
    endtask

    task automatic send_file();
        bit                have;
        bmpd_pkg::result_t r;
        foreach (file_bytes[i]) send_byte(file_bytes[i][7:0], file_bytes[i][8], have, r);
    endtask

    // Random file: mostly well formed, some with flaws, bad sizes or cut short.
    task automatic random_file();
        int w, h, bpp, off, flaw, cut, sel;
        sel  = $urandom_range(0, 19);
        w    = $urandom_range(1, 6);
        h    = $urandom_range(1, 4);
        if ($urandom_range(0, 1)) h = -h;
        bpp  = $urandom_range(0, 1) ? 32 : 24;
        off  = $urandom_range(0, 2) ? 54 : $urandom_range(34, 70);
        flaw = FLAW_NONE;
        cut  = -1;
        case (sel)
            0: flaw = $urandom_range(FLAW_SIG, FLAW_COMP);
            1: cut = $urandom_range(0, 80);
            2: if ($urandom_range(0, 1)) w = 0; else h = 0;
            3: bpp = $urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(1, 40);
            4: off = $urandom_range(0, 33);
            5: w = $urandom_range(0, 1) ? -$urandom_range(1, 9) : MAXW + $urandom_range(1, 9);
            6: h = $urandom_range(0, 1) ? MAXH + 1 : -(MAXH + $urandom_range(1, 9));
            default: ;
        endcase
        build_file(w, h, bpp, off, flaw, cut, $urandom_range(0, 2) ? 0 : $urandom_range(1, 3));
        send_file();
    endtask

    typedef struct {
        logic [7:0] d;
        logic       l;
        bit         has;
        logic [1:0] kind;
        logic [2:0] code;
    } dir_row_t;

    // Short directed requests around the signature, truncation and draining.
    dir_row_t dir_tab[10] = '{
        '{8'h42, 1'b0, 1'b0, bmpd_pkg::KIND_PIXEL, bmpd_pkg::ERR_NONE},
        '{8'h41, 1'b0, 1'b1, bmpd_pkg::KIND_ERROR, bmpd_pkg::ERR_SIGNATURE},
        '{8'hFF, 1'b0, 1'b0, bmpd_pkg::KIND_PIXEL, bmpd_pkg::ERR_NONE},
        '{8'h00, 1'b1, 1'b0, bmpd_pkg::KIND_PIXEL, bmpd_pkg::ERR_NONE},
        '{8'h00, 1'b1, 1'b1, bmpd_pkg::KIND_ERROR, bmpd_pkg::ERR_TRUNCATED},
        '{8'hFF, 1'b1, 1'b1, bmpd_pkg::KIND_ERROR, bmpd_pkg::ERR_TRUNCATED},
        '{8'h42, 1'b0, 1'b0, bmpd_pkg::KIND_PIXEL, bmpd_pkg::ERR_NONE},
        '{8'h4D, 1'b1, 1'b1, bmpd_pkg::KIND_ERROR, bmpd_pkg::ERR_TRUNCATED},
        '{8'h4D, 1'b0, 1'b0, bmpd_pkg::KIND_PIXEL, bmpd_pkg::ERR_NONE},
        '{8'h42, 1'b1, 1'b1, bmpd_pkg::KIND_ERROR, bmpd_pkg::ERR_SIGNATURE}
    };

    // Result receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        m_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge clk);
            end
            else
            begin
                m_tready = 1'b1;
            end
        end
    end

    // Result checker against the oldest pending expectation.
    always @(posedge clk)
    begin
        bmpd_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result kind=%0d data=%h", m_tuser, m_tdata);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser != want.result_kind)
                begin
                    $error("result_kind exp %0d got %0d", want.result_kind, m_tuser); errors++;
                end
                if (m_tdata[7:0] != want.red)
                begin
                    $error("red exp %0d got %0d", want.red, m_tdata[7:0]); errors++;
                end
                if (m_tdata[15:8] != want.green)
                begin
                    $error("green exp %0d got %0d", want.green, m_tdata[15:8]); errors++;
                end
                if (m_tdata[23:16] != want.blue)
                begin
                    $error("blue exp %0d got %0d", want.blue, m_tdata[23:16]); errors++;
                end
                if (m_tdata[31:24] != want.alpha)
                begin
                    $error("alpha exp %0d got %0d", want.alpha, m_tdata[31:24]); errors++;
                end
                if (m_tdata[43:32] != want.column)
                begin
                    $error("column exp %0d got %0d", want.column, m_tdata[43:32]); errors++;
                end
                if (m_tdata[55:44] != want.row)
                begin
                    $error("row exp %0d got %0d", want.row, m_tdata[55:44]); errors++;
                end
                if (m_tdata[68:56] != want.width_out)
                begin
                    $error("width_out exp %0d got %0d", want.width_out, m_tdata[68:56]);
                    errors++;
                end
                if (m_tdata[81:69] != want.height_out)
                begin
                    $error("height_out exp %0d got %0d", want.height_out, m_tdata[81:69]);
                    errors++;
                end
                if (m_tdata[82] != want.top_down_out)
                begin
                    $error("top_down_out exp %0d got %0d", want.top_down_out, m_tdata[82]);
                    errors++;
                end
                if (m_tdata[85:83] != want.error_code)
                begin
                    $error("error_code exp %0d got %0d", want.error_code, m_tdata[85:83]);
                    errors++;
                end
                if (m_tlast != want.image_end)
                begin
                    $error("image_end exp %0d got %0d", want.image_end, m_tlast); errors++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        bit                have;
        bmpd_pkg::result_t r;
        int                sent;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        clear_decoder();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed rows, with the obvious outcomes typed in.
        foreach (dir_tab[i])
        begin
            send_byte(dir_tab[i].d, dir_tab[i].l, have, r);
            if (have != dir_tab[i].has ||
                (have && (r.result_kind != dir_tab[i].kind ||
                          r.error_code != dir_tab[i].code)))
            begin
                $error("directed row %0d: exp has=%0d kind=%0d code=%0d got %0d %0d %0d",
                       i, dir_tab[i].has, dir_tab[i].kind, dir_tab[i].code,
                       have, r.result_kind, r.error_code);
                errors++;
            end
        end

        // Directed files at the size limits and each header check but the signature.
        build_file(MAXW, 1, 24, 54, FLAW_NONE, 200, 0);       send_file();
        build_file(1, -MAXH, 32, 34, FLAW_NONE, 60, 0);       send_file();
        build_file(MAXW + 1, 1, 24, 54, FLAW_NONE, -1, 0);    send_file();
        build_file(3, 2, 24, 33, FLAW_NONE, -1, 0);           send_file();
        build_file(2, -2, 32, 54, FLAW_INFO, -1, 0);          send_file();
        build_file(2, 2, 32, 54, FLAW_PLANE, -1, 0);          send_file();
        build_file(2, 2, 16, 54, FLAW_NONE, -1, 0);           send_file();
        build_file(2, 2, 24, 54, FLAW_COMP, -1, 0);           send_file();
        build_file(0, 3, 24, 54, FLAW_NONE, -1, 2);           send_file();
        build_file(1, 1, 24, 34, FLAW_NONE, -1, 0);           send_file();

        // Sender pauses until every pending result has drained.
        @(negedge clk);
        s_tvalid = 1'b0;
        wait (pending_results.size() == 0);

        // Random files; one long receiver hold-off early on, no idling at the end.
        sent = 0;
        while (sent < 1500)
        begin
            if (sent == 0) hold_req = 1'b1;
            if (sent > 1250) quiet = 1'b1;
            random_file();
            sent += file_bytes.size();
        end
        @(negedge clk);
        s_tvalid = 1'b0;

        wait (pending_results.size() == 0);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[bmp_to_rgba_decoder_unit.f]
hdl/bmpd_pkg.sv
hdl/bmpd_parser.sv
hdl/bmpd_queue.sv
hdl/bmp_to_rgba_decoder_unit.sv
tb/bmp_to_rgba_decoder_unit_tb.sv
